/* hw/rtl/otst_pkg.sv */
// shared constants, codes and types of the one-shot timer slot table
package otst_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = 32;
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int KIND_W    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED        = 3'd0,
    KIND_CREATE_FAILED  = 3'd1,
    KIND_DELETED        = 3'd2,
    KIND_FIRED          = 3'd3,
    KIND_NONE           = 3'd4
  } kind_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] wr_data;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
  } mem_ctl_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [SLOT_W-1:0] id;
    logic              last;
  } emit_t;

endpackage

/* hw/rtl/otst_if.sv */
// valid/ready channel interfaces for input and result words
interface otst_in_if import otst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CNT_W-1:0]  timeout;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output op, output timeout, output slot, input ready);
  modport sink (input valid, input op, input timeout, input slot, output ready);
endinterface

interface otst_out_if import otst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot_id;
  logic              last;

  modport source (output valid, output kind, output slot_id, output last, input ready);
  modport sink (input valid, input kind, input slot_id, input last, output ready);
endinterface

/* hw/rtl/one_shot_timer_slot_table_core.sv */
// top level of the one-shot timer slot table
//
// in_ch takes one word at a time: op tick, create (timeout) or delete (slot).
// out_ch returns result words (kind, slot_id, last); last marks the final
// word of the run that one input word causes. Op code 3 gives no result.
// in_ch.ready is high only while the sequencer is idle; one item at a time.
// Delete and zero-timeout create: result loaded into the output register
// from the emit state once it is free. Create walks free flags one slot a
// cycle and ends in the emit state at the first free slot or, when the table
// is full, at the last slot. Tick: the deadline memory has one registered
// read port and a single comparator, so each slot passes a read state and a
// compare state; output stalls hold the walk. The sequencer is idle again,
// with in_ch.ready high, in the cycle after the last load.
// The output register lets the next input word be taken while the last
// result still waits; when out_ch.ready is low the walk holds at the next
// firing slot and no word is lost.
// Reset (rst_n low, synchronous) clears the tick counter, all busy flags and
// the output valid flag; deadline entries are written on create before use.
module one_shot_timer_slot_table_core import otst_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  otst_in_if.sink  in_ch,
  otst_out_if.source out_ch
);

  emit_t                emit;
  mem_ctl_t             ctl;
  logic [CNT_W-1:0]     rd_data;
  logic [NUM_SLOTS-1:0] busy;
  logic                 out_free;
  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [SLOT_W-1:0]    out_id_r;
  logic                 out_last_r;

  assign out_free = !out_valid_r || out_ch.ready;

  otst_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_op      (in_ch.op),
    .in_timeout (in_ch.timeout),
    .in_slot    (in_ch.slot),
    .in_ready   (in_ch.ready),
    .out_free   (out_free),
    .emit       (emit),
    .ctl        (ctl),
    .rd_data    (rd_data),
    .busy       (busy)
  );

  otst_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (rd_data),
    .busy    (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_kind_r <= emit.kind;
      out_id_r   <= emit.id;
      out_last_r <= emit.last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.kind    = out_kind_r;
  assign out_ch.slot_id = out_id_r;
  assign out_ch.last    = out_last_r;

  // a new word never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result word loaded into a full output register");

  // the block stays busy after taking a word that has results
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready &&
     (in_ch.op == OP_TICK || in_ch.op == OP_CREATE || in_ch.op == OP_DELETE))
    |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // an empty tick is always a run of one word
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && (emit.kind == KIND_NONE)) |-> emit.last)
    else $error("empty tick result without last");

endmodule

/* hw/rtl/otst_slot_mem.sv */
// deadline memory with registered read and busy flags per slot
module otst_slot_mem import otst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mem_ctl_t             ctl,
  output logic [CNT_W-1:0]     rd_data,
  output logic [NUM_SLOTS-1:0] busy
);

  logic [CNT_W-1:0]     mem [NUM_SLOTS];
  logic [CNT_W-1:0]     rd_data_r;
  logic [NUM_SLOTS-1:0] busy_r;
  logic [NUM_SLOTS-1:0] busy_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.addr];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (ctl.wr_en) begin
      busy_nxt[ctl.addr] = 1'b1;
    end
    if (ctl.clr_en) begin
      busy_nxt[ctl.clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

/* hw/rtl/otst_seq.sv */
// sequencer with the shared deadline comparator and tick counter
module otst_seq import otst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [OP_W-1:0]      in_op,
  input  logic [CNT_W-1:0]     in_timeout,
  input  logic [SLOT_W-1:0]    in_slot,
  output logic                 in_ready,
  input  logic                 out_free,
  output emit_t                emit,
  output mem_ctl_t             ctl,
  input  logic [CNT_W-1:0]     rd_data,
  input  logic [NUM_SLOTS-1:0] busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TREAD,
    S_TCMP,
    S_CFIND,
    S_EMIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  dl_r, dl_nxt;
  logic              pend_v_r, pend_v_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0] pend_id_r, pend_id_nxt;
  logic              hit;
  logic              stall;

  assign hit   = busy[idx_r] && (rd_data == count_r);
  assign stall = hit && pend_v_r && !out_free;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    dl_nxt        = dl_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    in_ready      = (state_r == S_IDLE);
    ctl           = '0;
    emit          = '{valid: 1'b0, kind: KIND_NONE, id: '0, last: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_TICK: begin
              count_nxt  = count_r + 1'b1;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = S_TREAD;
            end
            OP_CREATE: begin
              if (in_timeout == '0) begin
                pend_kind_nxt = KIND_CREATE_FAILED;
                pend_id_nxt   = '0;
                state_nxt     = S_EMIT;
              end else begin
                dl_nxt    = count_r + in_timeout;
                idx_nxt   = '0;
                state_nxt = S_CFIND;
              end
            end
            OP_DELETE: begin
              if (32'(in_slot) < NUM_SLOTS) begin
                ctl.clr_en   = 1'b1;
                ctl.clr_addr = IDX_W'(in_slot);
              end
              pend_kind_nxt = KIND_DELETED;
              pend_id_nxt   = in_slot;
              state_nxt     = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_TREAD: begin
        ctl.rd_en = 1'b1;
        ctl.addr  = idx_r;
        state_nxt = S_TCMP;
      end
      S_TCMP: begin
        if (!stall) begin
          if (hit) begin
            ctl.clr_en   = 1'b1;
            ctl.clr_addr = idx_r;
            if (pend_v_r) begin
              emit = '{valid: 1'b1, kind: KIND_FIRED, id: pend_id_r, last: 1'b0};
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = KIND_FIRED;
            pend_id_nxt   = SLOT_W'(idx_r);
          end
          if (idx_r == LAST_IDX) begin
            if (!hit && !pend_v_r) begin
              pend_kind_nxt = KIND_NONE;
              pend_id_nxt   = '0;
            end
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TREAD;
          end
        end
      end
      S_CFIND: begin
        if (!busy[idx_r]) begin
          ctl.wr_en     = 1'b1;
          ctl.addr      = idx_r;
          ctl.wr_data   = dl_r;
          pend_kind_nxt = KIND_CREATED;
          pend_id_nxt   = SLOT_W'(idx_r);
          state_nxt     = S_EMIT;
        end else if (idx_r == LAST_IDX) begin
          pend_kind_nxt = KIND_CREATE_FAILED;
          pend_id_nxt   = '0;
          state_nxt     = S_EMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = '{valid: 1'b1, kind: pend_kind_r, id: pend_id_r, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r        <= dl_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
  end

endmodule

/* test/one_shot_timer_slot_table_core_checker.sv */
// checker: predicts timer table result words from accepted input words and compares them
module one_shot_timer_slot_table_core_checker import otst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  otst_in_if   in_ch,
  otst_out_if  out_ch,
  output int   mismatches,
  output int   words_pending
);

  localparam int MAX_FIRED = 16;
  localparam int PRINT_CAP = 60;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot_id;
    logic              last;
  } event_word_t;

  logic [CNT_W-1:0]     tick_now;
  logic [NUM_SLOTS-1:0] busy_map;
  logic [CNT_W-1:0]     due_at [NUM_SLOTS];
  event_word_t          expected_events [$];
  event_word_t          oldest;
  int                   words_seen;

  initial begin
    mismatches    = 0;
    words_pending = 0;
    words_seen    = 0;
    tick_now      = '0;
    busy_map      = '0;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at %0t, result word %0d: %s", $time, words_seen, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic void expect_word(kind_t kind, int id, logic last);
    event_word_t w;
    w.kind    = kind;
    w.slot_id = SLOT_W'(id);
    w.last    = last;
    expected_events.push_back(w);
  endfunction

  function automatic void predict_timer_events(logic [OP_W-1:0] op,
                                               logic [CNT_W-1:0] timeout,
                                               logic [SLOT_W-1:0] slot);
    int fired;
    int free_slot;
    event_word_t final_word;
    fired     = 0;
    free_slot = -1;
    case (op)
      OP_TICK: begin
        tick_now = tick_now + 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (fired < MAX_FIRED && busy_map[i] && due_at[i] == tick_now) begin
            busy_map[i] = 1'b0;
            expect_word(KIND_FIRED, i, 1'b0);
            fired++;
          end
        end
        if (fired == 0) begin
          expect_word(KIND_NONE, 0, 1'b1);
        end else begin
          final_word      = expected_events.pop_back();
          final_word.last = 1'b1;
          expected_events.push_back(final_word);
        end
      end
      OP_CREATE: begin
        if (timeout != '0) begin
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!busy_map[i]) free_slot = i;
          end
        end
        if (free_slot < 0) begin
          expect_word(KIND_CREATE_FAILED, 0, 1'b1);
        end else begin
          busy_map[free_slot] = 1'b1;
          due_at[free_slot]   = tick_now + timeout;
          expect_word(KIND_CREATED, free_slot, 1'b1);
        end
      end
      OP_DELETE: begin
        if (int'(slot) < NUM_SLOTS) busy_map[slot] = 1'b0;
        expect_word(KIND_DELETED, int'(slot), 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_now = '0;
      busy_map = '0;
      expected_events.delete();
      words_pending = 0;
    end else begin
      // a word leaving now was caused by an earlier input word
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d slot %0d last %0d",
                                    out_ch.kind, out_ch.slot_id, out_ch.last));
        end else begin
          oldest = expected_events.pop_front();
          check_field("kind", 8'(out_ch.kind), 8'(oldest.kind));
          check_field("slot_id", 8'(out_ch.slot_id), 8'(oldest.slot_id));
          check_field("last", 8'(out_ch.last), 8'(oldest.last));
        end
        words_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_timer_events(in_ch.op, in_ch.timeout, in_ch.slot);
      end
      words_pending = expected_events.size();
    end
  end

endmodule

/* test/one_shot_timer_slot_table_core_tb.sv */
// testbench top: stimulus, handshake pacing, watchdog and verdict for the timer slot table
module one_shot_timer_slot_table_core_tb;
  import otst_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_WORDS    = 80;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   hold_req;
  int   mismatches;
  int   words_pending;

  otst_in_if  in_ch();
  otst_out_if out_ch();

  one_shot_timer_slot_table_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  one_shot_timer_slot_table_core_checker event_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_word(logic [OP_W-1:0] op, logic [CNT_W-1:0] timeout,
                           logic [SLOT_W-1:0] slot);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.timeout <= timeout;
    in_ch.slot    <= slot;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly short timers and ticks so that timers fire, with some noise
  task automatic issue_random(output bit counted);
    int pick;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 45) begin
      send_word(OP_TICK, $urandom(), SLOT_W'($urandom()));
    end else if (pick < 80) begin
      send_word(OP_CREATE, $urandom_range(1, 12), SLOT_W'($urandom()));
    end else if (pick < 90) begin
      send_word(OP_DELETE, $urandom(), SLOT_W'($urandom_range(0, 15)));
    end else if (pick < 93) begin
      send_word(OP_CREATE, $urandom(), SLOT_W'($urandom()));
    end else if (pick < 96) begin
      send_word(OP_CREATE, '0, SLOT_W'($urandom()));
    end else begin
      send_word(OP_UNUSED, $urandom(), SLOT_W'($urandom()));
      counted = 1'b0;
    end
  endtask

  // receiver pacing, with a long hold-off on request
  initial begin
    int hold_left;
    int seen_req;
    hold_left    = 0;
    seen_req     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen_req) begin
        seen_req  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int sent;
    bit counted;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_TICK;
    in_ch.timeout = '0;
    in_ch.slot    = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_req      = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // empty tick, rejected and extreme timeouts, ignored op, deletes, full table
    send_word(OP_TICK, '0, '0);
    send_word(OP_CREATE, '0, 4'hf);
    send_word(OP_CREATE, '1, '0);
    send_word(OP_UNUSED, 32'h5a5a_a5a5, 4'ha);
    send_word(OP_DELETE, '1, 4'd15);
    send_word(OP_DELETE, '0, 4'd0);
    repeat (NUM_SLOTS) send_word(OP_CREATE, 32'd2, '0);
    send_word(OP_CREATE, 32'd5, '0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_TICK, '0, '0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 82;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 82;
        end
        default: begin
          tx_idle_pct  = 21;
          rx_stall_pct = 21;
        end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if (phase == 0 && sent == 30 && hold_req == 0) hold_req++;
        issue_random(counted);
        if (counted) sent++;
      end
      drain_results();
    end

    if (mismatches == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
